/* rtl/dwl_pkg.sv */
`timescale 1ns / 1ps
package dwl_pkg;

    localparam int LEN_W   = 7;
    localparam int COEF_W  = 16;
    localparam int OUT_W   = 18;
    localparam int TSEL_W  = 2;
    localparam int FRAC    = 15;

    // Configuration register indexes.
    localparam logic [1:0] REG_DIRECTION   = 2'd0;
    localparam logic [1:0] REG_TAP_SELECT  = 2'd1;
    localparam logic [1:0] REG_LINE_LENGTH = 2'd2;

    // Coefficient set codes.
    localparam logic [TSEL_W-1:0] TAPS_4 = 2'd0;
    localparam logic [TSEL_W-1:0] TAPS_6 = 2'd1;
    localparam logic [TSEL_W-1:0] TAPS_8 = 2'd2;

    // One finished line handed from the loader to the compute engine.
    typedef struct packed {
        logic              dir;
        logic [TSEL_W-1:0] taps;
        logic [LEN_W-1:0]  len;
    } job_t;

    // Number of taps in a coefficient set; the unused code acts as eight taps.
    function automatic logic [3:0] tap_count(input logic [TSEL_W-1:0] sel);
        logic [3:0] n;
        unique case (sel)
            TAPS_4:  n = 4'd4;
            TAPS_6:  n = 4'd6;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

    // Daubechies taps normalised to a sum of sqrt(2), signed Q1.15.
    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TSEL_W-1:0] sel,
                                                          input logic [2:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        unique case (sel)
            TAPS_4: begin
                case (idx)
                    3'd0:    c = 16'sd15826;
                    3'd1:    c = 16'sd27411;
                    3'd2:    c = 16'sd7345;
                    3'd3:    c = -16'sd4240;
                    default: c = '0;
                endcase
            end
            TAPS_6: begin
                case (idx)
                    3'd0:    c = 16'sd10901;
                    3'd1:    c = 16'sd26440;
                    3'd2:    c = 16'sd15069;
                    3'd3:    c = -16'sd4424;
                    3'd4:    c = -16'sd2800;
                    3'd5:    c = 16'sd1154;
                    default: c = '0;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    c = 16'sd7549;
                    3'd1:    c = 16'sd23424;
                    3'd2:    c = 16'sd20673;
                    3'd3:    c = -16'sd917;
                    3'd4:    c = -16'sd6129;
                    3'd5:    c = 16'sd1011;
                    3'd6:    c = 16'sd1078;
                    default: c = -16'sd347;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

/* rtl/dwl_front.sv */
`timescale 1ns / 1ps
module dwl_front #(
    parameter int MAX_LINE    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     sample_re,
    input  logic signed [SAMPLE_BITS-1:0]     sample_im,
    input  logic                              direction,
    input  logic [dwl_pkg::TSEL_W-1:0]        tap_select,
    input  logic [dwl_pkg::LEN_W-1:0]         line_length,
    input  logic                              line_done,
    input  logic                              q_full,
    output logic                              q_push,
    output dwl_pkg::job_t                     q_job,
    output logic                              mem_we,
    output logic [AW-1:0]                     mem_addr,
    output logic [2*SAMPLE_BITS-1:0]          mem_wdata
);

    localparam logic [dwl_pkg::LEN_W-1:0] MAX_EVEN =
        dwl_pkg::LEN_W'(MAX_LINE - (MAX_LINE % 2));

    logic [AW-1:0]              cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [dwl_pkg::LEN_W-1:0]  eff_len;
    logic [dwl_pkg::LEN_W-1:0]  cnt_inc;
    logic                       accept;
    logic                       line_end;

    // Effective line length: even, at least two, at most the store depth.
    always_comb
    begin
        eff_len = {line_length[dwl_pkg::LEN_W-1:1], 1'b0};
        if (eff_len > MAX_EVEN)
        begin
            eff_len = MAX_EVEN;
        end
        if (eff_len < dwl_pkg::LEN_W'(2))
        begin
            eff_len = dwl_pkg::LEN_W'(2);
        end
    end

    assign in_ready = !busy_reg && !q_full;
    assign accept   = in_valid && in_ready;
    assign cnt_inc  = dwl_pkg::LEN_W'(cnt_reg) + dwl_pkg::LEN_W'(1);
    assign line_end = cnt_inc >= eff_len;

    // Each accepted item is written into the line store.
    assign mem_we    = accept;
    assign mem_addr  = cnt_reg;
    assign mem_wdata = {sample_im, sample_re};

    // The last item of a line hands a job to the engine.
    assign q_push     = accept && line_end;
    assign q_job.dir  = direction;
    assign q_job.taps = tap_select;
    assign q_job.len  = eff_len;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            cnt_next = line_end ? '0 : AW'(cnt_inc);
        end
        if (q_push)
        begin
            busy_next = 1'b1;
        end
        else if (line_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

endmodule

/* rtl/dwl_queue.sv */
`timescale 1ns / 1ps
module dwl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dwl_pkg::job_t push_job,
    input  logic          pop,
    output dwl_pkg::job_t pop_job,
    output logic          full,
    output logic          empty
);

    dwl_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Job slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/dwl_back.sv */
`timescale 1ns / 1ps
module dwl_back #(
    parameter int MAX_LINE    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 mem_we,
    input  logic [AW-1:0]                        mem_addr,
    input  logic [2*SAMPLE_BITS-1:0]             mem_wdata,
    input  logic                                 q_empty,
    input  dwl_pkg::job_t                        q_job,
    output logic                                 q_pop,
    output logic                                 line_done,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dwl_pkg::OUT_W-1:0]     coef_re,
    output logic signed [dwl_pkg::OUT_W-1:0]     coef_im,
    output logic                                 last_out
);

    localparam int LW    = dwl_pkg::LEN_W;
    localparam int PW    = SAMPLE_BITS + dwl_pkg::COEF_W;
    localparam int ACC_W = PW + 3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HOLD  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    dwl_pkg::job_t              job_reg, job_next;
    logic [LW-1:0]              j_reg, j_next;
    logic [2:0]                 s_reg, s_next;

    logic [2*SAMPLE_BITS-1:0]   mem [MAX_LINE];
    logic [2*SAMPLE_BITS-1:0]   rd_reg;

    logic signed [dwl_pkg::COEF_W-1:0] coef_a_reg;
    logic                       va_reg, fa_reg, la_reg;
    logic signed [PW-1:0]       prod_re_reg, prod_im_reg;
    logic                       vb_reg, fb_reg, lb_reg;
    logic signed [ACC_W-1:0]    acc_re_reg, acc_im_reg;
    logic                       vc_reg, lc_reg;
    logic                       out_valid_reg;
    logic signed [dwl_pkg::OUT_W-1:0] coef_re_reg, coef_im_reg;
    logic                       last_reg;

    logic [LW-1:0]              n, h, itf, kf, iti, iw, ia, addr7;
    logic [3:0]                 nt, idx, s4;
    logic                       lowhalf, neg, last_term, last_out_idx, issue, fin;
    logic signed [dwl_pkg::COEF_W-1:0] coef;

    // Term address and coefficient for output j, term s.
    always_comb
    begin
        n            = job_reg.len;
        h            = n >> 1;
        nt           = dwl_pkg::tap_count(job_reg.taps);
        s4           = {1'b0, s_reg};
        lowhalf      = j_reg < h;
        itf          = lowhalf ? j_reg : j_reg - h;
        kf           = {itf[LW-2:0], 1'b0} + LW'(s_reg);
        if (kf > n - LW'(1))
        begin
            kf = n - LW'(1);
        end
        iti          = j_reg >> 1;
        iw           = LW'(s_reg[2:1]);
        ia           = (iti >= iw) ? iti - iw : '0;
        if (s_reg[0])
        begin
            ia = ia + h;
        end
        if (!job_reg.dir)
        begin
            addr7 = kf;
            idx   = lowhalf ? s4 : nt - 4'd1 - s4;
            neg   = !lowhalf && s_reg[0];
        end
        else
        begin
            addr7 = ia;
            if (!j_reg[0])
            begin
                idx = s_reg[0] ? nt - s4 : s4;
            end
            else
            begin
                idx = s_reg[0] ? nt - 4'd1 - s4 : s4 + 4'd1;
            end
            neg   = j_reg[0] && s_reg[0];
        end
        coef         = dwl_pkg::tap_coef(job_reg.taps, idx[2:0]);
        if (neg)
        begin
            coef = -coef;
        end
        last_term    = s4 == nt - 4'd1;
        last_out_idx = j_reg == n - LW'(1);
    end

    assign issue     = state_reg == S_ISSUE;
    assign fin       = vc_reg && lc_reg;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign line_done = issue && last_term && last_out_idx;

    // Sequencer: one output at a time, one term per cycle.
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    job_next   = q_job;
                    j_next     = '0;
                    s_next     = '0;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (last_term)
                begin
                    s_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    s_next = s_reg + 3'd1;
                end
            end
            S_DRAIN:
            begin
                if (fin)
                begin
                    if (last_out_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + LW'(1);
                        state_next = S_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= '0;
            j_reg     <= '0;
            s_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            j_reg     <= j_next;
            s_reg     <= s_next;
        end
    end

    // Line store with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_reg <= mem[addr7[AW-1:0]];
    end

    // Multiply-accumulate pipeline: read, multiply, accumulate.
    always_ff @(posedge clk)
    begin
        coef_a_reg  <= coef;
        prod_re_reg <= PW'($signed(rd_reg[SAMPLE_BITS-1:0]) * coef_a_reg);
        prod_im_reg <= PW'($signed(rd_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]) * coef_a_reg);
        if (vb_reg)
        begin
            acc_re_reg <= fb_reg ? ACC_W'(prod_re_reg) : acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= fb_reg ? ACC_W'(prod_im_reg) : acc_im_reg + ACC_W'(prod_im_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            fa_reg <= 1'b0;
            la_reg <= 1'b0;
            vb_reg <= 1'b0;
            fb_reg <= 1'b0;
            lb_reg <= 1'b0;
            vc_reg <= 1'b0;
            lc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= issue;
            fa_reg <= s_reg == 3'd0;
            la_reg <= last_term;
            vb_reg <= va_reg;
            fb_reg <= fa_reg;
            lb_reg <= la_reg;
            vc_reg <= vb_reg;
            lc_reg <= lb_reg;
        end
    end

    // Round half up, drop the fraction, saturate to the output range.
    function automatic logic signed [dwl_pkg::OUT_W-1:0] finish(
        input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]  rnd;
        logic signed [47:0]     wide;
        logic signed [dwl_pkg::OUT_W-1:0] r;
        rnd  = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (dwl_pkg::FRAC - 1));
        wide = 48'($signed(rnd[ACC_W:dwl_pkg::FRAC]));
        if (wide > 48'sd131071)
        begin
            r = 18'sd131071;
        end
        else if (wide < -48'sd131072)
        begin
            r = -18'sd131072;
        end
        else
        begin
            r = wide[dwl_pkg::OUT_W-1:0];
        end
        return r;
    endfunction

    // Output register.
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            coef_re_reg <= finish(acc_re_reg);
            coef_im_reg <= finish(acc_im_reg);
            last_reg    <= last_out_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign coef_re   = coef_re_reg;
    assign coef_im   = coef_im_reg;
    assign last_out  = last_reg;

endmodule

/* rtl/daubechies_wavelet_line.sv */
`timescale 1ns / 1ps
// Load: one item per cycle while the engine is free; the line's last item queues a job.
// Compute: each result is summed one term per cycle through a single
// multiply-accumulate pipeline, one result at a time.
// Reset clears control state and sets direction 0, four taps, line length 64.
module daubechies_wavelet_line #(
    parameter int MAX_LINE    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [dwl_pkg::LEN_W-1:0]            cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample_re,
    input  logic signed [SAMPLE_BITS-1:0]        sample_im,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dwl_pkg::OUT_W-1:0]     coef_re,
    output logic signed [dwl_pkg::OUT_W-1:0]     coef_im,
    output logic                                 last_out
);

    localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    logic                              direction_reg;
    logic [dwl_pkg::TSEL_W-1:0]        tap_select_reg;
    logic [dwl_pkg::LEN_W-1:0]         line_length_reg;
    logic                              q_push, q_pop, q_full, q_empty, line_done;
    dwl_pkg::job_t                     push_job, pop_job;
    logic                              mem_we;
    logic [AW-1:0]                     mem_addr;
    logic [2*SAMPLE_BITS-1:0]          mem_wdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= 1'b0;
            tap_select_reg  <= dwl_pkg::TAPS_4;
            line_length_reg <= dwl_pkg::LEN_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dwl_pkg::REG_DIRECTION:   direction_reg   <= cfg_wdata[0];
                dwl_pkg::REG_TAP_SELECT:  tap_select_reg  <= cfg_wdata[dwl_pkg::TSEL_W-1:0];
                dwl_pkg::REG_LINE_LENGTH: line_length_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    dwl_front #(
        .MAX_LINE    (MAX_LINE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_re   (sample_re),
        .sample_im   (sample_im),
        .direction   (direction_reg),
        .tap_select  (tap_select_reg),
        .line_length (line_length_reg),
        .line_done   (line_done),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata)
    );

    dwl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    dwl_back #(
        .MAX_LINE    (MAX_LINE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .q_empty   (q_empty),
        .q_job     (pop_job),
        .q_pop     (q_pop),
        .line_done (line_done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .coef_re   (coef_re),
        .coef_im   (coef_im),
        .last_out  (last_out)
    );

endmodule
